/* rtl/pwcm_pkg.sv */
// Shared types, field layout and the term-to-monomial table for the polynomial warp map.
// Used by every module of the block; depends on nothing.
package pwcm_pkg;

    localparam int COEFF_W    = 64;
    localparam int COEFF_HALF = 32;
    localparam int PIX_W      = 12;
    localparam int OUT_W      = 32;
    localparam int IDX_W      = 4;
    localparam int ORD_W      = 2;

    // stream layout
    localparam int S_TDATA_W  = 96;
    localparam int AXIS_LSB   = 0;
    localparam int IDX_LSB    = 1;
    localparam int VALUE_LSB  = 5;
    localparam int COL_LSB    = 69;
    localparam int ROW_LSB    = 81;
    localparam int M_TDATA_W  = 72;
    localparam int OUT_PAD    = M_TDATA_W - (2 * OUT_W + 1);

    localparam logic       CMD_LOAD = 1'b0;
    localparam logic       CMD_EVAL = 1'b1;

    localparam logic [ORD_W-1:0] ORDER_MIN   = 2'd1;
    localparam logic [ORD_W-1:0] ORDER_RESET = 2'd1;

    // Q.40 sum to Q.12
    localparam int ROUND_SHIFT = 28;

    localparam logic [OUT_W-1:0] SRC_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SRC_MIN = 32'h8000_0000;

    // canonical monomial slots, order-3 term numbering
    localparam int MONO_COUNT = 10;
    localparam int MONO_IDX_W = 4;
    localparam logic [MONO_IDX_W-1:0] MONO_ONE  = 4'd0;
    localparam logic [MONO_IDX_W-1:0] MONO_X    = 4'd1;
    localparam logic [MONO_IDX_W-1:0] MONO_X2   = 4'd2;
    localparam logic [MONO_IDX_W-1:0] MONO_X3   = 4'd3;
    localparam logic [MONO_IDX_W-1:0] MONO_Y    = 4'd4;
    localparam logic [MONO_IDX_W-1:0] MONO_XY   = 4'd5;
    localparam logic [MONO_IDX_W-1:0] MONO_X2Y  = 4'd6;
    localparam logic [MONO_IDX_W-1:0] MONO_Y2   = 4'd7;
    localparam logic [MONO_IDX_W-1:0] MONO_XY2  = 4'd8;
    localparam logic [MONO_IDX_W-1:0] MONO_Y3   = 4'd9;
    localparam logic [MONO_IDX_W-1:0] MONO_NONE = 4'd15;

    typedef struct packed {
        logic               cmd;
        logic               axis;
        logic [IDX_W-1:0]   idx;
        logic [COEFF_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic                    saturated;
        logic signed [OUT_W-1:0] src_y;
        logic signed [OUT_W-1:0] src_x;
    } res_t;

    // monomial used by term k of a polynomial of the given order
    function automatic logic [MONO_IDX_W-1:0] mono_sel(input logic [ORD_W-1:0] order,
                                                       input logic [IDX_W-1:0] k);
        logic [MONO_IDX_W-1:0] sel;
        sel = MONO_NONE;
        case (order)
            2'd1: begin
                case (k)
                    4'd0:    sel = MONO_ONE;
                    4'd1:    sel = MONO_X;
                    4'd2:    sel = MONO_Y;
                    default: sel = MONO_NONE;
                endcase
            end
            2'd2: begin
                case (k)
                    4'd0:    sel = MONO_ONE;
                    4'd1:    sel = MONO_X;
                    4'd2:    sel = MONO_X2;
                    4'd3:    sel = MONO_Y;
                    4'd4:    sel = MONO_XY;
                    4'd5:    sel = MONO_Y2;
                    default: sel = MONO_NONE;
                endcase
            end
            2'd3: begin
                case (k)
                    4'd0:    sel = MONO_ONE;
                    4'd1:    sel = MONO_X;
                    4'd2:    sel = MONO_X2;
                    4'd3:    sel = MONO_X3;
                    4'd4:    sel = MONO_Y;
                    4'd5:    sel = MONO_XY;
                    4'd6:    sel = MONO_X2Y;
                    4'd7:    sel = MONO_Y2;
                    4'd8:    sel = MONO_XY2;
                    4'd9:    sel = MONO_Y3;
                    default: sel = MONO_NONE;
                endcase
            end
            default: sel = MONO_NONE;
        endcase
        return sel;
    endfunction

endpackage

/* rtl/polynomial_warp_coordinate_map_top.sv */
// Pipeline: an evaluate transfer passes eight register stages before its result is on m_tdata
// (input, two monomial, two product, two sum, output).
// Throughput: one item per clock while m_tready stays high, set by the fully pipelined term multipliers;
// a load takes one input slot and yields no result. Stalls propagate back by stage.
// Reset: valid bits clear, the coefficient store reads zero, poly_order returns to 1.
// Top level; depends on pwcm_pkg, pwcm_mono, pwcm_term and pwcm_accum.
module polynomial_warp_coordinate_map_top #(
    parameter int MAX_ORDER  = 3,
    parameter int COORD_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pwcm_pkg::ORD_W-1:0]     cfg_wr_data,   // poly_order
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // coeff_axis, coeff_index, coeff_value, pixel_col, pixel_row, zero pad
    input  logic [pwcm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,       // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // src_x, src_y, saturated, zero pad
    output logic [pwcm_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int MB    = MAX_ORDER * COORD_BITS;
    localparam int TERMS = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2;
    localparam int PB    = pwcm_pkg::COEFF_W + MB;
    localparam logic [pwcm_pkg::ORD_W-1:0] MAX_ORD = pwcm_pkg::ORD_W'(MAX_ORDER);

    logic [pwcm_pkg::ORD_W-1:0] order_reg, order_next, order_eff;

    logic                  v1_reg, v1_next, en1;
    pwcm_pkg::cmd_t        cmd_in, cmd1_reg;
    logic [COORD_BITS-1:0] x_in, y_in, x1_reg, y1_reg;

    logic                  mono_ready, mono_valid, term_ready, term_valid, acc_ready;
    pwcm_pkg::cmd_t        mono_cmd;
    logic [MB-1:0]         mono_w [pwcm_pkg::MONO_COUNT];
    logic signed [PB-1:0]  term_w [2][TERMS];
    pwcm_pkg::res_t        res_w;

    assign order_next = cfg_wr_en ? cfg_wr_data : order_reg;

    // zero acts as first order, anything above the build limit as the limit
    always_comb begin
        if (order_reg == '0) begin
            order_eff = pwcm_pkg::ORDER_MIN;
        end else if (order_reg > MAX_ORD) begin
            order_eff = MAX_ORD;
        end else begin
            order_eff = order_reg;
        end
    end

    always_comb begin
        cmd_in.cmd   = s_tuser;
        cmd_in.axis  = s_tdata[pwcm_pkg::AXIS_LSB];
        cmd_in.idx   = s_tdata[pwcm_pkg::IDX_LSB +: pwcm_pkg::IDX_W];
        cmd_in.value = s_tdata[pwcm_pkg::VALUE_LSB +: pwcm_pkg::COEFF_W];
    end

    assign x_in = COORD_BITS'(s_tdata[pwcm_pkg::COL_LSB +: pwcm_pkg::PIX_W]);
    assign y_in = COORD_BITS'(s_tdata[pwcm_pkg::ROW_LSB +: pwcm_pkg::PIX_W]);

    assign en1      = !v1_reg || mono_ready;
    assign s_tready = en1;
    assign v1_next  = en1 ? s_tvalid : v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            order_reg <= pwcm_pkg::ORDER_RESET;
        end else begin
            v1_reg    <= v1_next;
            order_reg <= order_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            cmd1_reg <= cmd_in;
            x1_reg   <= x_in;
            y1_reg   <= y_in;
        end
    end

    pwcm_mono #(
        .MAX_ORDER  (MAX_ORDER),
        .COORD_BITS (COORD_BITS)
    ) u_mono (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_ready  (mono_ready),
        .in_cmd    (cmd1_reg),
        .in_x      (x1_reg),
        .in_y      (y1_reg),
        .out_valid (mono_valid),
        .out_ready (term_ready),
        .out_cmd   (mono_cmd),
        .out_mono  (mono_w)
    );

    pwcm_term #(
        .MAX_ORDER  (MAX_ORDER),
        .COORD_BITS (COORD_BITS)
    ) u_term (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .order     (order_eff),
        .in_valid  (mono_valid),
        .in_ready  (term_ready),
        .in_cmd    (mono_cmd),
        .in_mono   (mono_w),
        .out_valid (term_valid),
        .out_ready (acc_ready),
        .out_term  (term_w)
    );

    pwcm_accum #(
        .MAX_ORDER  (MAX_ORDER),
        .COORD_BITS (COORD_BITS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (term_valid),
        .in_ready  (acc_ready),
        .in_term   (term_w),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res_w)
    );

    assign m_tdata = {{pwcm_pkg::OUT_PAD{1'b0}}, res_w};

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result transfer offered straight after reset");

endmodule

/* rtl/pwcm_mono.sv */
// Two register stages that build every monomial x^a * y^b with a+b <= 3.
// Depends on pwcm_pkg; carries the command payload alongside.
module pwcm_mono #(
    parameter int  MAX_ORDER  = 3,
    parameter int  COORD_BITS = 12,
    localparam int MB         = MAX_ORDER * COORD_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pwcm_pkg::cmd_t    in_cmd,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    output logic              out_valid,
    input  logic              out_ready,
    output pwcm_pkg::cmd_t    out_cmd,
    output logic [MB-1:0]     out_mono [pwcm_pkg::MONO_COUNT]
);

    localparam int W2 = 2 * COORD_BITS;
    localparam int W3 = 3 * COORD_BITS;

    logic                  v2_reg, v2_next, v3_reg, v3_next;
    logic                  en2, en3;
    pwcm_pkg::cmd_t        cmd2_reg, cmd3_reg;
    logic [COORD_BITS-1:0] xa_reg, ya_reg;
    logic [W2-1:0]         xx_reg, yy_reg, xy_reg;
    logic [W2-1:0]         xx_next, yy_next, xy_next;
    logic [W3-1:0]         x3_w, x2y_w, xy2_w, y3_w;
    logic [MB-1:0]         mono_reg  [pwcm_pkg::MONO_COUNT];
    logic [MB-1:0]         mono_next [pwcm_pkg::MONO_COUNT];

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    assign v2_next = en2 ? in_valid : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;

    assign xx_next = W2'(in_x) * W2'(in_x);
    assign yy_next = W2'(in_y) * W2'(in_y);
    assign xy_next = W2'(in_x) * W2'(in_y);

    assign x3_w  = W3'(xx_reg) * W3'(xa_reg);
    assign x2y_w = W3'(xx_reg) * W3'(ya_reg);
    assign xy2_w = W3'(yy_reg) * W3'(xa_reg);
    assign y3_w  = W3'(yy_reg) * W3'(ya_reg);

    always_comb begin
        mono_next[pwcm_pkg::MONO_ONE] = MB'(1);
        mono_next[pwcm_pkg::MONO_X]   = MB'(xa_reg);
        mono_next[pwcm_pkg::MONO_X2]  = MB'(xx_reg);
        mono_next[pwcm_pkg::MONO_X3]  = MB'(x3_w);
        mono_next[pwcm_pkg::MONO_Y]   = MB'(ya_reg);
        mono_next[pwcm_pkg::MONO_XY]  = MB'(xy_reg);
        mono_next[pwcm_pkg::MONO_X2Y] = MB'(x2y_w);
        mono_next[pwcm_pkg::MONO_Y2]  = MB'(yy_reg);
        mono_next[pwcm_pkg::MONO_XY2] = MB'(xy2_w);
        mono_next[pwcm_pkg::MONO_Y3]  = MB'(y3_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            cmd2_reg <= in_cmd;
            xa_reg   <= in_x;
            ya_reg   <= in_y;
            xx_reg   <= xx_next;
            yy_reg   <= yy_next;
            xy_reg   <= xy_next;
        end
        if (en3) begin
            cmd3_reg <= cmd2_reg;
            mono_reg <= mono_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_cmd   = cmd3_reg;
    assign out_mono  = mono_reg;

endmodule

/* rtl/pwcm_term.sv */
// Coefficient store and the per-term products, split into partial products of the 32-bit coefficient halves.
// Depends on pwcm_pkg; loads are written here in stream order and dropped.
module pwcm_term #(
    parameter int  MAX_ORDER  = 3,
    parameter int  COORD_BITS = 12,
    localparam int MB         = MAX_ORDER * COORD_BITS,
    localparam int TERMS      = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2,
    localparam int PB         = pwcm_pkg::COEFF_W + MB
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [pwcm_pkg::ORD_W-1:0] order,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pwcm_pkg::cmd_t       in_cmd,
    input  logic [MB-1:0]        in_mono [pwcm_pkg::MONO_COUNT],
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [PB-1:0] out_term [2][TERMS]
);

    localparam int ML   = (MB + 1) / 2;
    localparam int MH   = MB - ML;
    localparam int HW   = pwcm_pkg::COEFF_HALF;
    localparam int LL_W = HW + ML;
    localparam int LH_W = HW + MH;
    localparam int HL_W = HW + ML + 1;
    localparam int HH_W = HW + MH + 1;
    localparam int SA_W = $clog2(2 * TERMS);

    logic [pwcm_pkg::COEFF_W-1:0] coef_reg [2 * TERMS];
    logic                         store_we;
    logic                         load_xfer;
    logic [SA_W-1:0]              wr_addr;

    logic v4_reg, v4_next, v5_reg, v5_next;
    logic en4, en5;

    logic [LL_W-1:0]        ll_reg [2][TERMS], ll_next [2][TERMS];
    logic [LH_W-1:0]        lh_reg [2][TERMS], lh_next [2][TERMS];
    logic signed [HL_W-1:0] hl_reg [2][TERMS], hl_next [2][TERMS];
    logic signed [HH_W-1:0] hh_reg [2][TERMS], hh_next [2][TERMS];
    logic signed [PB-1:0]   term_reg [2][TERMS], term_next [2][TERMS];

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    assign load_xfer = in_valid && in_ready && (in_cmd.cmd == pwcm_pkg::CMD_LOAD);
    // out-of-range term numbers are ignored
    assign store_we  = load_xfer && (in_cmd.idx < pwcm_pkg::IDX_W'(TERMS));
    assign wr_addr   = in_cmd.axis ? (SA_W'(TERMS) + SA_W'(in_cmd.idx)) : SA_W'(in_cmd.idx);

    assign v4_next = en4 ? (in_valid && (in_cmd.cmd == pwcm_pkg::CMD_EVAL)) : v4_reg;
    assign v5_next = en5 ? v4_reg : v5_reg;

    for (genvar a = 0; a < 2; a++) begin : g_axis
        for (genvar k = 0; k < TERMS; k++) begin : g_term
            logic [pwcm_pkg::COEFF_W-1:0]    coef_w;
            logic [pwcm_pkg::MONO_IDX_W-1:0] sel_w;
            logic [MB-1:0]                   mono_w;

            assign coef_w = coef_reg[a * TERMS + k];
            assign sel_w  = pwcm_pkg::mono_sel(order, pwcm_pkg::IDX_W'(k));

            // terms beyond the current order see a zero monomial
            always_comb begin
                mono_w = '0;
                for (int m = 0; m < pwcm_pkg::MONO_COUNT; m++) begin
                    if (sel_w == pwcm_pkg::MONO_IDX_W'(m)) begin
                        mono_w = in_mono[m];
                    end
                end
            end

            assign ll_next[a][k] = LL_W'(coef_w[HW-1:0]) * LL_W'(mono_w[ML-1:0]);
            assign lh_next[a][k] = LH_W'(coef_w[HW-1:0]) * LH_W'(mono_w[MB-1:ML]);
            assign hl_next[a][k] = HL_W'($signed(coef_w[pwcm_pkg::COEFF_W-1:HW]))
                                 * HL_W'($signed({1'b0, mono_w[ML-1:0]}));
            assign hh_next[a][k] = HH_W'($signed(coef_w[pwcm_pkg::COEFF_W-1:HW]))
                                 * HH_W'($signed({1'b0, mono_w[MB-1:ML]}));

            assign term_next[a][k] = (PB'(hh_reg[a][k]) <<< (HW + ML))
                                   + (PB'(hl_reg[a][k]) <<< HW)
                                   + (PB'(lh_reg[a][k]) << ML)
                                   + PB'(ll_reg[a][k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < 2 * TERMS; e++) begin
                coef_reg[e] <= '0;
            end
        end else if (store_we) begin
            coef_reg[wr_addr] <= in_cmd.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (en5) begin
            term_reg <= term_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_term  = term_reg;

    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        store_we |=> coef_reg[$past(wr_addr)] == $past(in_cmd.value))
        else $error("coefficient store did not take the loaded value");

    a_load_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        load_xfer |=> !v4_reg)
        else $error("load transfer occupied an evaluation slot");

endmodule

/* rtl/pwcm_accum.sv */
// Sums the terms of each polynomial, rounds Q.40 to Q.12 and saturates to 32 bits.
// Depends on pwcm_pkg; the last stage is the output register of the block.
module pwcm_accum #(
    parameter int  MAX_ORDER  = 3,
    parameter int  COORD_BITS = 12,
    localparam int MB         = MAX_ORDER * COORD_BITS,
    localparam int TERMS      = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2,
    localparam int PB         = pwcm_pkg::COEFF_W + MB
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [PB-1:0] in_term [2][TERMS],
    output logic                 out_valid,
    input  logic                 out_ready,
    output pwcm_pkg::res_t       out_res
);

    localparam int SB     = PB + $clog2(TERMS + 1);
    localparam int GROUPS = (TERMS + 3) / 4;
    localparam int HI_W   = SB - pwcm_pkg::ROUND_SHIFT - pwcm_pkg::OUT_W + 1;
    localparam logic signed [SB-1:0] HALF = SB'(1) << (pwcm_pkg::ROUND_SHIFT - 1);

    logic v6_reg, v6_next, v7_reg, v7_next, v8_reg, v8_next;
    logic en6, en7, en8;

    logic signed [SB-1:0] pad_w     [2][GROUPS * 4];
    logic signed [SB-1:0] grp_reg   [2][GROUPS], grp_next [2][GROUPS];
    logic signed [SB-1:0] total_reg [2], total_next [2];
    logic signed [SB-1:0] shifted_w [2];
    logic [pwcm_pkg::OUT_W-1:0] coord_w [2];
    logic                 clip_w    [2];
    pwcm_pkg::res_t       res_reg, res_next;

    assign en8      = !v8_reg || out_ready;
    assign en7      = !v7_reg || en8;
    assign en6      = !v6_reg || en7;
    assign in_ready = en6;

    assign v6_next = en6 ? in_valid : v6_reg;
    assign v7_next = en7 ? v6_reg : v7_reg;
    assign v8_next = en8 ? v7_reg : v8_reg;

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic [HI_W-1:0] hi_w;

        for (genvar i = 0; i < GROUPS * 4; i++) begin : g_pad
            if (i < TERMS) begin : g_used
                assign pad_w[a][i] = SB'(in_term[a][i]);
            end else begin : g_zero
                assign pad_w[a][i] = '0;
            end
        end

        for (genvar g = 0; g < GROUPS; g++) begin : g_grp
            assign grp_next[a][g] = pad_w[a][4*g] + pad_w[a][4*g+1]
                                  + pad_w[a][4*g+2] + pad_w[a][4*g+3];
        end

        // fold in the rounding half so the last stage only shifts and clips
        always_comb begin
            total_next[a] = HALF;
            for (int g = 0; g < GROUPS; g++) begin
                total_next[a] = total_next[a] + grp_reg[a][g];
            end
        end

        assign shifted_w[a] = total_reg[a] >>> pwcm_pkg::ROUND_SHIFT;
        assign hi_w         = shifted_w[a][SB-1-pwcm_pkg::ROUND_SHIFT:pwcm_pkg::OUT_W-1];
        assign clip_w[a]    = !((&hi_w) || !(|hi_w));
        assign coord_w[a]   = !clip_w[a] ? shifted_w[a][pwcm_pkg::OUT_W-1:0]
                            : (total_reg[a][SB-1] ? pwcm_pkg::SRC_MIN : pwcm_pkg::SRC_MAX);
    end

    always_comb begin
        res_next.src_x     = coord_w[0];
        res_next.src_y     = coord_w[1];
        res_next.saturated = clip_w[0] || clip_w[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else begin
            v6_reg <= v6_next;
            v7_reg <= v7_next;
            v8_reg <= v8_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en6) begin
            grp_reg <= grp_next;
        end
        if (en7) begin
            total_reg <= total_next;
        end
        if (en8) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v8_reg;
    assign out_res   = res_reg;

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        v7_reg && en8 |=> v8_reg)
        else $error("item lost between sum and output register");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        v8_reg && res_reg.saturated |->
            (res_reg.src_x == pwcm_pkg::SRC_MAX) || (res_reg.src_x == pwcm_pkg::SRC_MIN) ||
            (res_reg.src_y == pwcm_pkg::SRC_MAX) || (res_reg.src_y == pwcm_pkg::SRC_MIN))
        else $error("saturation flag set without a clipped coordinate");

endmodule

/* tb/testbench.sv */
// Self-checking bench for polynomial_warp_coordinate_map_top: coefficient loads, pixel evaluation,
// order settings, rounding and saturation, all checked against a bit-exact in-bench predictor.
// Depends on pwcm_pkg and polynomial_warp_coordinate_map_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORDER   = 3;
    localparam int NUM_TERMS   = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2;
    localparam int PIPE_DEPTH  = 8;
    localparam int IDLE_PCT    = 27;
    localparam int RANDOM_ITEMS = 950;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    localparam logic signed [pwcm_pkg::COEFF_W-1:0] COEFF_ONE = 64'sd1 <<< 40;
    localparam logic signed [pwcm_pkg::COEFF_W-1:0] COEFF_HALF_LSB =
        64'sd1 <<< (pwcm_pkg::ROUND_SHIFT - 1);
    localparam logic signed [127:0] ROUND_BIAS = 128'sd1 <<< (pwcm_pkg::ROUND_SHIFT - 1);
    localparam logic signed [127:0] Q12_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q12_MIN = -128'sd2147483648;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [pwcm_pkg::ORD_W-1:0]       cfg_wr_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [pwcm_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                             s_tuser = pwcm_pkg::CMD_LOAD;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [pwcm_pkg::M_TDATA_W-1:0]   m_tdata;

    // predictor state
    logic [pwcm_pkg::ORD_W-1:0]          poly_order = pwcm_pkg::ORDER_RESET;
    logic signed [pwcm_pkg::COEFF_W-1:0] coeff_store [2][NUM_TERMS];
    pwcm_pkg::res_t                      expected_points [$];

    int unsigned error_count = 0;
    int unsigned random_sent = 0;
    bit          steady = 1'b0;

    polynomial_warp_coordinate_map_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        for (int a = 0; a < 2; a++)
            for (int k = 0; k < NUM_TERMS; k++)
                coeff_store[a][k] = '0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function automatic logic [63:0] upower(input logic [pwcm_pkg::PIX_W-1:0] base,
                                           input int e);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < e; i++)
            r = r * base;
        return r;
    endfunction

    function automatic int active_order();
        int ord;
        ord = (poly_order < pwcm_pkg::ORDER_MIN) ? int'(pwcm_pkg::ORDER_MIN)
                                                 : int'(poly_order);
        if (ord > MAX_ORDER)
            ord = MAX_ORDER;
        return ord;
    endfunction

    // total degree of term k at the current order, -1 where the term is unused
    function automatic int term_degree(input int k);
        int n;
        n = 0;
        for (int ye = 0; ye <= active_order(); ye++)
            for (int xe = 0; xe + ye <= active_order(); xe++) begin
                if (n == k)
                    return xe + ye;
                n++;
            end
        return -1;
    endfunction

    // round Q.40 to Q.12 with halves toward +inf, then clip to 32 bits
    function automatic logic signed [pwcm_pkg::OUT_W-1:0] to_q12(
        input logic signed [127:0] acc, inout logic clipped);
        logic signed [127:0] q;
        q = (acc + ROUND_BIAS) >>> pwcm_pkg::ROUND_SHIFT;
        if (q > Q12_MAX) begin
            clipped = 1'b1;
            return pwcm_pkg::SRC_MAX;
        end
        if (q < Q12_MIN) begin
            clipped = 1'b1;
            return pwcm_pkg::SRC_MIN;
        end
        return q[pwcm_pkg::OUT_W-1:0];
    endfunction

    function automatic pwcm_pkg::res_t warp_point(input logic [pwcm_pkg::PIX_W-1:0] col,
                                                  input logic [pwcm_pkg::PIX_W-1:0] row);
        pwcm_pkg::res_t r;
        logic signed [127:0] sum_x, sum_y, mono, cx, cy;
        logic clipped;
        int k;
        sum_x = '0;
        sum_y = '0;
        clipped = 1'b0;
        k = 0;
        for (int ye = 0; ye <= active_order(); ye++)
            for (int xe = 0; xe + ye <= active_order(); xe++) begin
                mono = {64'd0, upower(col, xe) * upower(row, ye)};
                cx = coeff_store[AXIS_X][k];
                cy = coeff_store[AXIS_Y][k];
                sum_x += cx * mono;
                sum_y += cy * mono;
                k++;
            end
        r.src_x = to_q12(sum_x, clipped);
        r.src_y = to_q12(sum_y, clipped);
        r.saturated = clipped;
        return r;
    endfunction

    // one input transfer; the predictor is updated on acceptance
    task automatic send_item(input logic cmd, input logic axis,
                             input logic [pwcm_pkg::IDX_W-1:0] idx,
                             input logic [pwcm_pkg::COEFF_W-1:0] value,
                             input logic [pwcm_pkg::PIX_W-1:0] col,
                             input logic [pwcm_pkg::PIX_W-1:0] row);
        logic [pwcm_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[pwcm_pkg::AXIS_LSB] = axis;
        d[pwcm_pkg::IDX_LSB +: pwcm_pkg::IDX_W] = idx;
        d[pwcm_pkg::VALUE_LSB +: pwcm_pkg::COEFF_W] = value;
        d[pwcm_pkg::COL_LSB +: pwcm_pkg::PIX_W] = col;
        d[pwcm_pkg::ROW_LSB +: pwcm_pkg::PIX_W] = row;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (cmd == pwcm_pkg::CMD_LOAD) begin
            if (idx < NUM_TERMS)
                coeff_store[axis][idx] = value;
        end else begin
            expected_points.insert(expected_points.size(), warp_point(col, row));
        end
    endtask

    // unused fields carry random junk so the block must ignore them
    task automatic load_coeff(input logic axis, input logic [pwcm_pkg::IDX_W-1:0] idx,
                              input logic [pwcm_pkg::COEFF_W-1:0] value);
        send_item(pwcm_pkg::CMD_LOAD, axis, idx, value,
                  pwcm_pkg::PIX_W'($urandom), pwcm_pkg::PIX_W'($urandom));
    endtask

    task automatic eval_pixel(input logic [pwcm_pkg::PIX_W-1:0] col,
                              input logic [pwcm_pkg::PIX_W-1:0] row);
        send_item(pwcm_pkg::CMD_EVAL, 1'($urandom), pwcm_pkg::IDX_W'($urandom),
                  {$urandom, $urandom}, col, row);
    endtask

    // hold input until every result is back and loads have left the pipe
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(negedge aclk);
        repeat (PIPE_DEPTH + 2) @(negedge aclk);
    endtask

    task automatic set_order(input logic [pwcm_pkg::ORD_W-1:0] ord);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ord;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        poly_order = ord;
    endtask

    function automatic logic [pwcm_pkg::COEFF_W-1:0] pick_coeff(input int deg);
        logic [pwcm_pkg::COEFF_W-1:0] v;
        int w;
        v = {$urandom, $urandom};
        if (deg < 0 || $urandom_range(9) == 0)
            return v;
        // magnitude shrinks with degree so most outputs stay in range
        w = $urandom_range(54 - 12 * deg, 38 - 12 * deg);
        v = v & ((64'd1 << w) - 64'd1);
        if ($urandom_range(1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic logic [pwcm_pkg::PIX_W-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return pwcm_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_state();
        eval_pixel(12'd0, 12'd0);
        eval_pixel(12'd4095, 12'd4095);
    endtask

    task automatic test_linear_terms();
        load_coeff(AXIS_X, 4'd0, COEFF_ONE);
        load_coeff(AXIS_X, 4'd1, COEFF_ONE);
        load_coeff(AXIS_Y, 4'd2, COEFF_ONE);
        // out-of-range indexes: drop without touching the store
        load_coeff(AXIS_X, 4'd10, 64'h7FFF_FFFF_FFFF_FFFF);
        load_coeff(AXIS_Y, 4'd15, 64'h8000_0000_0000_0000);
        eval_pixel(12'd4095, 12'd0);
        eval_pixel(12'd17, 12'd4095);
    endtask

    task automatic test_saturation_rounding();
        load_coeff(AXIS_X, 4'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        load_coeff(AXIS_Y, 4'd0, 64'h8000_0000_0000_0000);
        eval_pixel(12'd4095, 12'd4095);
        // exact halves of one output lsb, both signs
        load_coeff(AXIS_X, 4'd0, COEFF_HALF_LSB);
        load_coeff(AXIS_Y, 4'd0, -COEFF_HALF_LSB);
        eval_pixel(12'd0, 12'd0);
    endtask

    task automatic test_order_settings();
        // term 9 is only in use at the highest order
        load_coeff(AXIS_X, 4'd9, 64'sd1 <<< 28);
        load_coeff(AXIS_Y, 4'd5, -(64'sd1 <<< 30));
        set_order(2'd0);
        eval_pixel(12'd100, 12'd200);
        set_order(2'd2);
        eval_pixel(12'd4095, 12'd4095);
        set_order(2'd3);
        eval_pixel(12'd4095, 12'd4095);
    endtask

    task automatic load_full_set();
        for (int a = 0; a < 2; a++)
            for (int k = 0; k < NUM_TERMS; k++) begin
                load_coeff(1'(a), pwcm_pkg::IDX_W'(k), pick_coeff(term_degree(k)));
                random_sent++;
            end
    endtask

    task automatic test_random_warps();
        logic [pwcm_pkg::ORD_W-1:0] orders [8] =
            '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3};
        int phase;
        int r, k;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            set_order(phase < 8 ? orders[phase] : pwcm_pkg::ORD_W'($urandom));
            steady = (phase == 2);
            load_full_set();
            for (int i = 0; i < 95 && random_sent < RANDOM_ITEMS; i++) begin
                if (phase == 4 && i == 40)
                    drain_pipeline();
                r = $urandom_range(99);
                if (r < 8) begin
                    k = $urandom_range(NUM_TERMS - 1);
                    load_coeff(1'($urandom), pwcm_pkg::IDX_W'(k), pick_coeff(term_degree(k)));
                end else if (r < 11) begin
                    load_coeff(1'($urandom), pwcm_pkg::IDX_W'($urandom_range(15, NUM_TERMS)),
                               {$urandom, $urandom});
                end else begin
                    eval_pixel(pick_coord(), pick_coord());
                end
                random_sent++;
            end
            steady = 1'b0;
            phase++;
        end
    endtask

    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge aclk) begin : check_results
        pwcm_pkg::res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[2 * pwcm_pkg::OUT_W:0];
            if (expected_points.size() == 0) begin
                flag_error($sformatf("result transfer with nothing expected: %h", m_tdata));
            end else begin
                want = expected_points.pop_front();
                if (got.src_x !== want.src_x)
                    flag_error($sformatf("src_x got %0d want %0d", got.src_x, want.src_x));
                if (got.src_y !== want.src_y)
                    flag_error($sformatf("src_y got %0d want %0d", got.src_y, want.src_y));
                if (got.saturated !== want.saturated)
                    flag_error($sformatf("saturated got %b want %b",
                                         got.saturated, want.saturated));
                if (m_tdata[pwcm_pkg::M_TDATA_W-1:2 * pwcm_pkg::OUT_W + 1] !== '0)
                    flag_error($sformatf("padding not zero: %h", m_tdata));
            end
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_linear_terms();
        test_saturation_rounding();
        test_order_settings();
        test_random_warps();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (int i = 0; i < 20000 && expected_points.size() != 0; i++)
            @(posedge aclk);
        if (expected_points.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_points.size()));
        repeat (PIPE_DEPTH * 4) @(posedge aclk);
        if (error_count == 0) begin
            $display("** polynomial_warp_coordinate_map_top: PASSED **");
        end else begin
            $display("** polynomial_warp_coordinate_map_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** polynomial_warp_coordinate_map_top: FAILED **");
        $finish;
    end

endmodule
